// ===== design/twn_pkg.sv =====
// Shared constants, field widths and codes for the tiled 3D Worley noise block.
package twn_pkg;

  localparam int DEF_MAX_CELLS = 16;
  localparam int DEF_FRAC_BITS = 16;

  localparam int CC_W   = 5;
  localparam int SIZE_W = 9;
  localparam int VOX_W  = 8;
  localparam int FRAC_W = 16;
  localparam int CIDX_W = 12;
  localparam int DIST_W = 17;
  localparam int VIDX_W = 24;

  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_ADDR_W-1:0] REG_CELL_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_X     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Y     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Z     = 2'd3;

  localparam logic [CC_W-1:0]   RST_CELL_COUNT = 5'd4;
  localparam logic [SIZE_W-1:0] RST_SIZE       = 9'd128;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

endpackage

// ===== design/twn_div.sv =====
// Restoring divider, one quotient bit per cycle, with quotient and remainder.
module twn_div #(
  parameter int DW = 29,
  parameter int VW = twn_pkg::SIZE_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q;
  logic [VW-1:0] r;
  logic [VW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rs;
  logic [VW:0]   diff;

  always_comb begin
    rs   = {r, q[DW-1]};
    diff = rs - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      d   <= divisor;
      cnt <= CW'(DW);
    end else if (busy) begin
      if (rs >= {1'b0, d}) begin
        r <= diff[VW-1:0];
        q <= {q[DW-2:0], 1'b1};
      end else begin
        r <= rs[VW-1:0];
        q <= {q[DW-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

// ===== design/twn_sqrt.sv =====
// Truncating integer square root, one result bit per cycle.
module twn_sqrt #(
  parameter int W = 36
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   value,
  output logic [W/2-1:0] root,
  output logic           done
);

  logic [W-1:0] v;
  logic [W-1:0] res;
  logic [W-1:0] bitm;
  logic [W-1:0] trial;
  logic         busy;

  assign trial = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && bitm[0];
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      res  <= '0;
      bitm <= W'(1) << (W - 2);
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign root = res[W/2-1:0];

endmodule

// ===== design/tiled_worley_noise_3d_voxel.sv =====
// Tiled 3D Worley noise evaluator: feature table, neighbor scan and distance output.
// A load beat (tuser 0) writes one cell's feature offsets into the table.
// An evaluate beat (tuser 1) holds off the input while it runs two passes of the bit-serial
// dividers (voxel position, then cell wrap), 27 reads through the single read port of the
// feature table plus a drain of the read pipeline, the bit-pair square root, and the
// hand-off of the result. One evaluate is in flight at a time; a finished result waits
// in the output register while the next beat is accepted, and the next evaluate holds in
// its last step until that register is free.
// The table has no reset; evaluate only after loading every cell the scan can reach.
// Write configuration only while the block is idle.
module tiled_worley_noise_3d_voxel #(
  parameter int MAX_CELLS = twn_pkg::DEF_MAX_CELLS,
  parameter int FRAC_BITS = twn_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cell_index, frac_x, frac_y, frac_z, voxel_x, voxel_y, voxel_z, zero pad
  input  logic [twn_pkg::S_TDATA_W-1:0]   s_tdata,
  // op
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // distance, voxel_index, zero pad
  output logic [twn_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [twn_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [twn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import twn_pkg::*;

  localparam int DEPTH = MAX_CELLS * MAX_CELLS * MAX_CELLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(MAX_CELLS + 1);
  localparam int WW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int BW    = VOX_W + NW;
  localparam int DW    = BW + FRAC_BITS;
  localparam int DDW   = FRAC_BITS + 2;
  localparam int SQW   = 2 * FRAC_BITS + 2;
  localparam int SW    = 2 * FRAC_BITS + 4;
  localparam int RW    = SW / 2;
  localparam int FXW   = FRAC_W + FRAC_BITS;
  localparam int OSW   = FRAC_BITS + DIST_W;
  localparam int PYW   = WW + NW;
  localparam int PZW   = WW + 2 * NW;
  localparam int IXW   = PZW + 2;
  localparam int FEW   = 3 * FRAC_W;

  localparam int STW = 3;
  localparam logic [STW-1:0] ST_IDLE = 3'd0;
  localparam logic [STW-1:0] ST_DIV  = 3'd1;
  localparam logic [STW-1:0] ST_MOD  = 3'd2;
  localparam logic [STW-1:0] ST_SCAN = 3'd3;
  localparam logic [STW-1:0] ST_SQRT = 3'd4;
  localparam logic [STW-1:0] ST_OUT  = 3'd5;

  localparam logic [1:0] SEL_M = 2'd0;
  localparam logic [1:0] SEL_0 = 2'd1;
  localparam logic [1:0] SEL_P = 2'd2;

  logic [STW-1:0]    state;
  logic [CC_W-1:0]   cell_count;
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;

  logic [NW-1:0]     n_eff;
  logic [2*NW-1:0]   nn;
  logic [SIZE_W-1:0] sz_eff [3];

  logic              accept;
  logic              load_we;
  logic [CIDX_W-1:0] in_ci;
  logic [FEW-1:0]    in_feat;
  logic [VOX_W-1:0]  in_vox [3];
  logic [VOX_W-1:0]  vox_r  [3];

  logic              div_start;
  logic [DW-1:0]     div_dividend [3];
  logic [SIZE_W-1:0] div_divisor  [3];
  logic [DW-1:0]     div_q        [3];
  logic [SIZE_W-1:0] div_r        [3];
  logic              div_done     [3];
  logic              div_all_done;

  logic [DW-1:0]     pos  [3];
  logic [WW-1:0]     w0   [3];
  logic [WW-1:0]     wm   [3];
  logic [WW-1:0]     wp   [3];
  logic [WW-1:0]     rem_w  [3];
  logic [WW-1:0]     wm_next [3];
  logic [WW-1:0]     wp_next [3];

  logic              issuing;
  logic [1:0]        sel  [3];
  logic [WW-1:0]     wsel [3];
  logic              s1_v;
  logic [WW-1:0]     s1_wx;
  logic [PYW-1:0]    s1_py;
  logic [PZW-1:0]    s1_pz;
  logic [1:0]        s1_sel [3];
  logic [AW-1:0]     rd_addr;
  logic [FEW-1:0]    rdata;
  logic              s2_v;
  logic [1:0]        s2_sel [3];
  logic [FRAC_BITS-1:0] fr   [3];
  logic [DDW-1:0]    tdiff [3];
  logic [DDW-1:0]    dv    [3];
  logic [DDW-1:0]    negd  [3];
  logic [DDW-2:0]    absd  [3];
  logic              s3_v;
  logic [SQW-1:0]    s3_sq [3];
  logic [SW-1:0]     sum;
  logic [SW-1:0]     best;

  logic              sq_start;
  logic [RW-1:0]     sq_root;
  logic              sq_done;
  logic [RW-1:0]     root_r;
  logic [FRAC_BITS:0] clamped;
  logic [DIST_W-1:0] distance;

  logic [VOX_W+SIZE_W-1:0] ysx;
  logic [2*SIZE_W-1:0]     sxsy;
  logic [VOX_W+2*SIZE_W-1:0] zterm;
  logic [VIDX_W-1:0]       vidx;

  logic [FEW-1:0]    feat_mem [DEPTH];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_ci     = s_tdata[11:0];
  assign in_feat   = s_tdata[59:12];
  assign in_vox[0] = s_tdata[67:60];
  assign in_vox[1] = s_tdata[75:68];
  assign in_vox[2] = s_tdata[83:76];
  assign load_we  = accept && (s_tuser == OP_LOAD) && (32'(in_ci) < 32'(DEPTH));

  always_comb begin
    if (cell_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(cell_count) > 32'(MAX_CELLS)) begin
      n_eff = NW'(MAX_CELLS);
    end else begin
      n_eff = NW'(cell_count);
    end
    sz_eff[0] = (size_x == '0) ? SIZE_W'(1) : size_x;
    sz_eff[1] = (size_y == '0) ? SIZE_W'(1) : size_y;
    sz_eff[2] = (size_z == '0) ? SIZE_W'(1) : size_z;
  end

  assign div_all_done = div_done[0] && div_done[1] && div_done[2];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    always_comb begin
      if (state == ST_MOD) begin
        div_dividend[a] = DW'(pos[a][DW-1:FRAC_BITS]);
        div_divisor[a]  = SIZE_W'(n_eff);
      end else begin
        div_dividend[a] = DW'(BW'(vox_r[a]) * BW'(n_eff)) << FRAC_BITS;
        div_divisor[a]  = sz_eff[a];
      end
      rem_w[a]   = WW'(div_r[a]);
      wm_next[a] = (rem_w[a] == '0) ? WW'(n_eff - NW'(1)) : rem_w[a] - WW'(1);
      wp_next[a] = (NW'(rem_w[a]) == n_eff - NW'(1)) ? '0 : rem_w[a] + WW'(1);
      case (sel[a])
        SEL_M:   wsel[a] = wm[a];
        SEL_P:   wsel[a] = wp[a];
        default: wsel[a] = w0[a];
      endcase
      fr[a]    = FRAC_BITS'((FXW'(rdata[a*FRAC_W +: FRAC_W]) << FRAC_BITS) >> FRAC_W);
      tdiff[a] = {2'b00, pos[a][FRAC_BITS-1:0]} - {2'b00, fr[a]};
      case (s2_sel[a])
        SEL_M:   dv[a] = tdiff[a] + (DDW'(1) << FRAC_BITS);
        SEL_P:   dv[a] = tdiff[a] - (DDW'(1) << FRAC_BITS);
        default: dv[a] = tdiff[a];
      endcase
      negd[a] = -dv[a];
      absd[a] = dv[a][DDW-1] ? negd[a][DDW-2:0] : dv[a][DDW-2:0];
    end

    twn_div #(
      .DW (DW),
      .VW (SIZE_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (div_dividend[a]),
      .divisor  (div_divisor[a]),
      .quot     (div_q[a]),
      .rem      (div_r[a]),
      .done     (div_done[a])
    );
  end

  assign rd_addr = AW'(IXW'(s1_wx) + IXW'(s1_py) + IXW'(s1_pz));
  assign sum     = SW'(s3_sq[0]) + SW'(s3_sq[1]) + SW'(s3_sq[2]);

  twn_sqrt #(
    .W (SW)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (best),
    .root  (sq_root),
    .done  (sq_done)
  );

  assign clamped  = (root_r > (RW'(1) << FRAC_BITS)) ? (FRAC_BITS + 1)'(1) << FRAC_BITS
                                                     : root_r[FRAC_BITS:0];
  assign distance = DIST_W'((OSW'(clamped) << FRAC_W) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (load_we) begin
      feat_mem[AW'(in_ci)] <= in_feat;
    end
    rdata <= feat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cell_count <= RST_CELL_COUNT;
      size_x     <= RST_SIZE;
      size_y     <= RST_SIZE;
      size_z     <= RST_SIZE;
      div_start  <= 1'b0;
      sq_start   <= 1'b0;
      issuing    <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      s3_v       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      div_start <= ((state == ST_IDLE) && accept && (s_tuser == OP_EVAL))
                   || ((state == ST_DIV) && div_all_done);
      sq_start  <= (state == ST_SCAN) && !issuing && !s1_v && !s2_v && !s3_v;
      s1_v      <= issuing;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      if (cfg_we) begin
        case (cfg_addr)
          REG_CELL_COUNT: cell_count <= cfg_wdata[CC_W-1:0];
          REG_SIZE_X:     size_x     <= cfg_wdata;
          REG_SIZE_Y:     size_y     <= cfg_wdata;
          REG_SIZE_Z:     size_z     <= cfg_wdata;
          default:        ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && s_tuser == OP_EVAL) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_all_done) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (div_all_done) begin
            issuing <= 1'b1;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (sel[0] == SEL_P && sel[1] == SEL_P && sel[2] == SEL_P) begin
              issuing <= 1'b0;
            end
          end else if (!s1_v && !s2_v && !s3_v) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    nn    <= n_eff * n_eff;
    ysx   <= vox_r[1] * size_x;
    sxsy  <= size_x * size_y;
    zterm <= vox_r[2] * sxsy;
    vidx  <= VIDX_W'(zterm + (VOX_W+2*SIZE_W)'(ysx) + (VOX_W+2*SIZE_W)'(vox_r[0]));

    if (accept && s_tuser == OP_EVAL) begin
      vox_r[0] <= in_vox[0];
      vox_r[1] <= in_vox[1];
      vox_r[2] <= in_vox[2];
    end

    if (state == ST_DIV && div_all_done) begin
      pos[0] <= div_q[0];
      pos[1] <= div_q[1];
      pos[2] <= div_q[2];
    end

    if (state == ST_MOD && div_all_done) begin
      for (int a = 0; a < 3; a++) begin
        w0[a]  <= rem_w[a];
        wm[a]  <= wm_next[a];
        wp[a]  <= wp_next[a];
        sel[a] <= SEL_M;
      end
      best <= '1;
    end else if (state == ST_SCAN && issuing) begin
      sel[0] <= (sel[0] == SEL_P) ? SEL_M : sel[0] + 2'd1;
      if (sel[0] == SEL_P) begin
        sel[1] <= (sel[1] == SEL_P) ? SEL_M : sel[1] + 2'd1;
        if (sel[1] == SEL_P) begin
          sel[2] <= (sel[2] == SEL_P) ? SEL_M : sel[2] + 2'd1;
        end
      end
    end

    s1_wx <= wsel[0];
    s1_py <= PYW'(wsel[1]) * PYW'(n_eff);
    s1_pz <= PZW'(wsel[2]) * PZW'(nn);
    for (int a = 0; a < 3; a++) begin
      s1_sel[a] <= sel[a];
      s2_sel[a] <= s1_sel[a];
      s3_sq[a]  <= SQW'(absd[a]) * SQW'(absd[a]);
    end

    if (s3_v && sum < best) begin
      best <= sum;
    end

    if (sq_done) begin
      root_r <= sq_root;
    end

    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= M_TDATA_W'({vidx, distance});
    end
  end

endmodule
